### sv/wawsn_pkg.sv
// Package for the weekday alarm with snooze: field widths, command and
// event codes, configuration register indexes and the shared config struct.
// No dependencies.
`timescale 1ns / 1ps

package wawsn_pkg;

  // Alarm slots and field widths.
  localparam int NUM_ALARMS = 5;
  localparam int ALARM_W    = 19;
  localparam int SNOOZE_W   = 22;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int TICK_W     = 32;
  localparam int CMD_W      = 2;
  localparam int EV_W       = 2;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int DOW_W      = 3;
  localparam int DAYS_W     = 7;

  // Bit positions inside an alarm register.
  localparam int MIN_LSB  = 0;
  localparam int HOUR_LSB = 6;
  localparam int DAYS_LSB = 11;
  localparam int EN_BIT   = 18;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STOP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SNOOZE = 2'd2;

  // Radio events.
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_ON   = 2'd1;
  localparam logic [EV_W-1:0] EV_OFF  = 2'd2;

  // Configuration register indexes (alarms occupy 0 .. NUM_ALARMS-1).
  localparam logic [CFG_IDX_W-1:0] REG_SNOOZE_MS = 3'd5;

  // Constants of the time checks.
  localparam logic [SNOOZE_W-1:0] SNOOZE_RESET = 22'd120000;
  localparam logic [MIN_W-1:0]    NO_MINUTE    = 6'd61;
  localparam logic [HOUR_W-1:0]   MAX_HOUR     = 5'd23;
  localparam logic [MIN_W-1:0]    MAX_MINUTE   = 6'd59;
  localparam logic [MIN_W-1:0]    SECOND_ZERO  = 6'd0;
  localparam logic [DOW_W-1:0]    DOW_NONE     = 3'd0;

  typedef logic [NUM_ALARMS-1:0][ALARM_W-1:0] alarm_arr_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    alarm_arr_t          alarm;
    logic [SNOOZE_W-1:0] snooze_ms;
    logic                any_enabled;
  } cfg_t;

  // One accepted request.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [MIN_W-1:0]  second;
    logic [DOW_W-1:0]  weekday;
    logic [TICK_W-1:0] now_ms;
  } req_t;

endpackage

### sv/wawsn_ifs.sv
// Valid/ready channel interfaces of the weekday alarm: request, response
// and configuration write. Depends on wawsn_pkg.
`timescale 1ns / 1ps

interface wawsn_req_if import wawsn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic [MIN_W-1:0]  second;
  logic [DOW_W-1:0]  weekday;
  logic [TICK_W-1:0] now_ms;

  modport source (output valid, cmd, hour, minute, second, weekday, now_ms,
                  input ready);
  modport sink   (input valid, cmd, hour, minute, second, weekday, now_ms,
                  output ready);
endinterface

interface wawsn_rsp_if import wawsn_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            ringing;
  logic [EV_W-1:0] radio_event;
  logic            snooze_pending;
  logic            any_enabled;

  modport source (output valid, ringing, radio_event, snooze_pending, any_enabled,
                  input ready);
  modport sink   (input valid, ringing, radio_event, snooze_pending, any_enabled,
                  output ready);
endinterface

interface wawsn_cfg_if import wawsn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/wawsn_cfg_regs.sv
// Configuration register file: five alarm words and the snooze length,
// plus the any-alarm-enabled flag. Depends on wawsn_pkg.
`timescale 1ns / 1ps

module wawsn_cfg_regs import wawsn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  alarm_arr_t          alarm;
  logic [SNOOZE_W-1:0] snooze_ms;
  logic [NUM_ALARMS-1:0] enables;

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      alarm     <= '0;
      snooze_ms <= SNOOZE_RESET;
    end else if (wr_en) begin
      for (int i = 0; i < NUM_ALARMS; i++) begin
        if (wr_index == CFG_IDX_W'(i)) begin
          alarm[i] <= wr_data[ALARM_W-1:0];
        end
      end
      if (wr_index == REG_SNOOZE_MS) begin
        snooze_ms <= wr_data[SNOOZE_W-1:0];
      end
    end
  end

  // Enable bits of all alarms.
  always_comb begin
    for (int i = 0; i < NUM_ALARMS; i++) begin
      enables[i] = alarm[i][EN_BIT];
    end
  end

  assign cfg.alarm       = alarm;
  assign cfg.snooze_ms   = snooze_ms;
  assign cfg.any_enabled = |enables;

endmodule

### sv/wawsn_match.sv
// Alarm comparators: one per alarm slot, checking enable, weekday bit,
// hour and minute against the time of a check. Depends on wawsn_pkg.
`timescale 1ns / 1ps

module wawsn_match import wawsn_pkg::*; (
  input  alarm_arr_t            alarm,
  input  logic [HOUR_W-1:0]     hour,
  input  logic [MIN_W-1:0]      minute,
  input  logic [DOW_W-1:0]      weekday,
  output logic                  hit
);

  logic [NUM_ALARMS-1:0] hits;

  // Stored hour or minute out of range counts as zero. The weekday mask is
  // shifted up one place so that the weekday number indexes it directly.
  always_comb begin
    logic [HOUR_W-1:0] ah;
    logic [MIN_W-1:0]  am;
    logic [DAYS_W:0]   days_ext;
    for (int i = 0; i < NUM_ALARMS; i++) begin
      am       = alarm[i][MIN_LSB +: MIN_W];
      ah       = alarm[i][HOUR_LSB +: HOUR_W];
      days_ext = {alarm[i][DAYS_LSB +: DAYS_W], 1'b0};
      if (am > MAX_MINUTE) am = '0;
      if (ah > MAX_HOUR) ah = '0;
      hits[i] = alarm[i][EN_BIT] && days_ext[weekday] &&
                (ah == hour) && (am == minute);
    end
  end

  assign hit = |hits;

endmodule

### sv/wawsn_core.sv
// Request register, alarm state update and result register of the weekday
// alarm. Depends on wawsn_pkg and wawsn_match.
`timescale 1ns / 1ps

module wawsn_core import wawsn_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  req_t            in_req,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            ringing,
  output logic [EV_W-1:0] radio_event,
  output logic            snooze_pending,
  output logic            any_enabled
);

  // Request register.
  logic  req_valid;
  req_t  req;
  logic  advance;

  // Alarm state.
  logic              ring_flag, ring_flag_next;
  logic              snooze_flag, snooze_flag_next;
  logic [TICK_W-1:0] snooze_deadline, snooze_deadline_next;
  logic [MIN_W-1:0]  last_minute, last_minute_next;
  logic [EV_W-1:0]   ev_next;

  logic              alarm_hit;
  logic [TICK_W-1:0] since_deadline;

  // The held request moves on whenever the result register is free or drained.
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_req;
    end
  end

  wawsn_match u_match (
    .alarm   (cfg.alarm),
    .hour    (req.hour),
    .minute  (req.minute),
    .weekday (req.weekday),
    .hit     (alarm_hit)
  );

  assign since_deadline = req.now_ms - snooze_deadline;

  // Next state and radio event for the held request.
  always_comb begin
    logic new_minute;
    ring_flag_next       = ring_flag;
    snooze_flag_next     = snooze_flag;
    snooze_deadline_next = snooze_deadline;
    last_minute_next     = last_minute;
    ev_next              = EV_NONE;
    new_minute           = (req.second == SECOND_ZERO) && (req.minute != last_minute);
    case (req.cmd)
      CMD_CHECK: begin
        // A weekday of zero leaves everything as it was.
        if (req.weekday != DOW_NONE) begin
          if (new_minute) begin
            last_minute_next = req.minute;
          end
          // Deadline passed when the wrapped difference is non-negative.
          if ((snooze_flag && !since_deadline[TICK_W-1]) ||
              (new_minute && alarm_hit)) begin
            ring_flag_next   = 1'b1;
            snooze_flag_next = 1'b0;
            ev_next          = EV_ON;
          end
        end
      end
      CMD_STOP: begin
        ring_flag_next   = 1'b0;
        snooze_flag_next = 1'b0;
        ev_next          = EV_OFF;
      end
      CMD_SNOOZE: begin
        if (ring_flag) begin
          ring_flag_next       = 1'b0;
          snooze_flag_next     = 1'b1;
          snooze_deadline_next = req.now_ms + TICK_W'(cfg.snooze_ms);
          ev_next              = EV_OFF;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers update once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_flag       <= 1'b0;
      snooze_flag     <= 1'b0;
      snooze_deadline <= '0;
      last_minute     <= NO_MINUTE;
    end else if (advance) begin
      ring_flag       <= ring_flag_next;
      snooze_flag     <= snooze_flag_next;
      snooze_deadline <= snooze_deadline_next;
      last_minute     <= last_minute_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ringing        <= ring_flag_next;
      radio_event    <= ev_next;
      snooze_pending <= snooze_flag_next;
      any_enabled    <= cfg.any_enabled;
    end
  end

endmodule

### sv/weekday_alarm_with_snooze.sv
// Top level of the weekday alarm with snooze: channel hookup, config
// registers and the request/result pipeline. Depends on wawsn_pkg,
// wawsn_ifs, wawsn_cfg_regs and wawsn_core.
//
//   Channel  Direction  Carries
//   req      in         cmd, hour, minute, second, weekday, now_ms
//   rsp      out        ringing, radio_event, snooze_pending, any_enabled
//   cfg      in         index, data (register write, always ready)
//
// An accepted request is loaded into the request register and its response
// into the result register once that register is free or drained. Throughput
// is one request per cycle while responses are taken; the state update is a
// single pass of five alarm comparators and one 32-bit deadline compare.
// Synchronous reset clears the alarm state and both valid flags.
// A stalled response holds the result register; one further request is
// held in the request register, then req.ready drops.
`timescale 1ns / 1ps

module weekday_alarm_with_snooze import wawsn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  wawsn_req_if.sink  req,
  wawsn_rsp_if.source rsp,
  wawsn_cfg_if.sink  cfg
);

  cfg_t cfg_q;
  req_t in_req;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  wawsn_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  assign in_req.cmd     = req.cmd;
  assign in_req.hour    = req.hour;
  assign in_req.minute  = req.minute;
  assign in_req.second  = req.second;
  assign in_req.weekday = req.weekday;
  assign in_req.now_ms  = req.now_ms;

  wawsn_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg_q),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .in_req         (in_req),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .ringing        (rsp.ringing),
    .radio_event    (rsp.radio_event),
    .snooze_pending (rsp.snooze_pending),
    .any_enabled    (rsp.any_enabled)
  );

  // A radio-on event always leaves the alarm ringing.
  a_on_rings: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.radio_event == EV_ON) |-> rsp.ringing)
    else $error("radio on reported without ringing");

  // Ringing and a pending snooze never hold together.
  a_ring_xor_snooze: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.ringing && rsp.snooze_pending))
    else $error("ringing while snooze is pending");

  // A request taken while the response stalls fills the only free slot, so
  // the next request can only enter as the response drains.
  a_fill_stall: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && rsp.valid && !rsp.ready) |=> (req.ready == rsp.ready))
    else $error("request accepted with no room behind a stalled response");

  // Only the three defined radio events appear.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.radio_event == EV_NONE || rsp.radio_event == EV_ON ||
                   rsp.radio_event == EV_OFF))
    else $error("undefined radio event");

endmodule

### tb/tb_weekday_alarm_with_snooze.sv
// Self-checking testbench for weekday_alarm_with_snooze: directed and random
// requests against a built-in alarm predictor. Depends on wawsn_pkg, wawsn_ifs
// and the block itself.
`timescale 1ns / 1ps

module tb_weekday_alarm_with_snooze;
  import wawsn_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int NUM_PHASES      = 7;

  // One response as the block reports it.
  typedef struct packed {
    logic            ringing;
    logic [EV_W-1:0] radio_event;
    logic            snooze_pending;
    logic            any_enabled;
  } alarm_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wawsn_req_if req_ch ();
  wawsn_rsp_if rsp_ch ();
  wawsn_cfg_if cfg_ch ();

  weekday_alarm_with_snooze dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven and statuses waiting to be returned.
  req_t          cmd_queue[$];
  alarm_status_t due_status[$];

  // Predictor state and its copy of the configuration.
  logic                ring_on;
  logic                snooze_armed;
  logic [TICK_W-1:0]   wake_at;
  logic [MIN_W-1:0]    last_min;
  alarm_arr_t          alarm_words;
  logic [SNOOZE_W-1:0] snooze_len;

  // Settings as the stimulus side knows them, and its running tick.
  alarm_arr_t          gen_alarms;
  logic [SNOOZE_W-1:0] gen_snooze;
  logic [TICK_W-1:0]   tick;

  int errors = 0;
  int status_checked = 0;
  int ring_starts = 0;
  int snoozes_armed = 0;
  int settings_used = 0;

  logic req_fired = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   stall_left = 0;
  int   run_left = 0;
  req_t next_req;

  // Apply one request to the predicted alarm state and return the status.
  function automatic alarm_status_t advance_alarm(req_t r);
    alarm_status_t      st;
    logic [TICK_W-1:0]  since_wake;
    logic [ALARM_W-1:0] word;
    logic [MIN_W-1:0]   al_min;
    logic [HOUR_W-1:0]  al_hour;
    logic [DAYS_W-1:0]  al_days;
    st = '0;
    st.radio_event = EV_NONE;
    case (r.cmd)
      CMD_CHECK: begin
        if (r.weekday != DOW_NONE) begin
          // A passed snooze deadline restarts ringing; the compare is wrap-safe.
          since_wake = r.now_ms - wake_at;
          if (snooze_armed && !since_wake[TICK_W-1]) begin
            ring_on = 1'b1;
            snooze_armed = 1'b0;
            st.radio_event = EV_ON;
          end
          // Alarms are scanned once per new minute, at second zero.
          if (r.second == SECOND_ZERO && r.minute != last_min) begin
            last_min = r.minute;
            for (int k = 0; k < NUM_ALARMS; k++) begin
              word    = alarm_words[k];
              al_min  = word[MIN_LSB +: MIN_W];
              al_hour = word[HOUR_LSB +: HOUR_W];
              al_days = word[DAYS_LSB +: DAYS_W];
              if (al_min > MAX_MINUTE) al_min = '0;
              if (al_hour > MAX_HOUR) al_hour = '0;
              if (word[EN_BIT] && al_days[r.weekday - 1] &&
                  al_hour == r.hour && al_min == r.minute) begin
                ring_on = 1'b1;
                snooze_armed = 1'b0;
                st.radio_event = EV_ON;
              end
            end
          end
        end
      end
      CMD_STOP: begin
        ring_on = 1'b0;
        snooze_armed = 1'b0;
        st.radio_event = EV_OFF;
      end
      CMD_SNOOZE: begin
        if (ring_on) begin
          ring_on = 1'b0;
          snooze_armed = 1'b1;
          wake_at = r.now_ms + TICK_W'(snooze_len);
          st.radio_event = EV_OFF;
          snoozes_armed++;
        end
      end
      default: ;
    endcase
    if (st.radio_event == EV_ON) ring_starts++;
    st.ringing = ring_on;
    st.snooze_pending = snooze_armed;
    st.any_enabled = 1'b0;
    for (int k = 0; k < NUM_ALARMS; k++) begin
      if (alarm_words[k][EN_BIT]) st.any_enabled = 1'b1;
    end
    return st;
  endfunction

  task automatic check_field(input string name, input logic [EV_W-1:0] want,
                             input logic [EV_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Model upkeep and response checking, all sampled at the rising edge.
  always @(posedge clk) begin
    alarm_status_t want;
    req_fired <= req_ch.valid && req_ch.ready;
    if (rst) begin
      ring_on      = 1'b0;
      snooze_armed = 1'b0;
      wake_at      = '0;
      last_min     = NO_MINUTE;
      alarm_words  = '0;
      snooze_len   = SNOOZE_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index < NUM_ALARMS)
          alarm_words[cfg_ch.index] = cfg_ch.data[ALARM_W-1:0];
        else if (cfg_ch.index == REG_SNOOZE_MS)
          snooze_len = cfg_ch.data[SNOOZE_W-1:0];
      end
      if (req_ch.valid && req_ch.ready) begin
        due_status.push_back(advance_alarm('{cmd: req_ch.cmd, hour: req_ch.hour,
                                             minute: req_ch.minute, second: req_ch.second,
                                             weekday: req_ch.weekday,
                                             now_ms: req_ch.now_ms}));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_status.size() == 0) begin
          $display("%0t ns: response with none expected, actual %b/%0d/%b/%b", $time,
                   rsp_ch.ringing, rsp_ch.radio_event, rsp_ch.snooze_pending,
                   rsp_ch.any_enabled);
          errors++;
        end else begin
          want = due_status.pop_front();
          check_field("ringing", EV_W'(want.ringing), EV_W'(rsp_ch.ringing));
          check_field("radio_event", want.radio_event, rsp_ch.radio_event);
          check_field("snooze_pending", EV_W'(want.snooze_pending),
                      EV_W'(rsp_ch.snooze_pending));
          check_field("any_enabled", EV_W'(want.any_enabled), EV_W'(rsp_ch.any_enabled));
          status_checked++;
        end
      end
    end
  end

  // Request driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fired) begin
      if (gap_left > 0 || cmd_queue.size() == 0) begin
        req_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        next_req = cmd_queue.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.cmd     <= next_req.cmd;
        req_ch.hour    <= next_req.hour;
        req_ch.minute  <= next_req.minute;
        req_ch.second  <= next_req.second;
        req_ch.weekday <= next_req.weekday;
        req_ch.now_ms  <= next_req.now_ms;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Response back-pressure: runs of ready broken by stalls, some runs long.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (run_left > 0) begin
        run_left = run_left - 1;
      end else begin
        run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      end
    end
  end

  task automatic add_req(input logic [CMD_W-1:0] cmd, input logic [HOUR_W-1:0] h,
                         input logic [MIN_W-1:0] m, input logic [MIN_W-1:0] s,
                         input logic [DOW_W-1:0] dow, input logic [TICK_W-1:0] now);
    cmd_queue.push_back('{cmd: cmd, hour: h, minute: m, second: s,
                          weekday: dow, now_ms: now});
  endtask

  function automatic logic [ALARM_W-1:0] pack_alarm(input logic en,
      input logic [DAYS_W-1:0] days, input logic [HOUR_W-1:0] h,
      input logic [MIN_W-1:0] m);
    return {en, days, h, m};
  endfunction

  // Mostly sane alarm times, mostly enabled where enabling is allowed, sometimes raw field values.
  function automatic logic [ALARM_W-1:0] random_alarm(input logic allow_enable);
    logic [ALARM_W-1:0] word;
    word = ALARM_W'($urandom_range(0, (1 << ALARM_W) - 1));
    if ($urandom_range(0, 9) < 8) begin
      word[HOUR_LSB +: HOUR_W] = HOUR_W'($urandom_range(0, 23));
      word[MIN_LSB +: MIN_W] = MIN_W'($urandom_range(0, 59));
    end
    word[EN_BIT] = allow_enable && ($urandom_range(0, 4) != 0);
    return word;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_config(input alarm_arr_t words, input logic [SNOOZE_W-1:0] len);
    for (int k = 0; k < NUM_ALARMS; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'(words[k]));
    write_reg(REG_SNOOZE_MS, CFG_DATA_W'(len));
    gen_alarms = words;
    gen_snooze = len;
    settings_used++;
  endtask

  // Block until every request is taken and every response has come back.
  task automatic wait_idle();
    while (cmd_queue.size() != 0 || req_ch.valid || due_status.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Half the requests aim at a configured alarm; the rest are commands and noise.
  task automatic add_random_req();
    req_t               r;
    int                 pick;
    int                 k;
    logic [ALARM_W-1:0] word;
    logic [DAYS_W-1:0]  days;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) tick = $urandom();
    else tick = tick + $urandom_range(0, gen_snooze / 3 + 2000);
    r.cmd     = CMD_CHECK;
    r.hour    = HOUR_W'($urandom_range(0, 31));
    r.minute  = MIN_W'($urandom_range(0, 63));
    r.second  = MIN_W'($urandom_range(0, 63));
    r.weekday = DOW_W'($urandom_range(0, 7));
    r.now_ms  = tick;
    if (pick < 50) begin
      k = $urandom_range(0, NUM_ALARMS - 1);
      word = gen_alarms[k];
      r.hour = word[HOUR_LSB +: HOUR_W];
      r.minute = word[MIN_LSB +: MIN_W];
      if ($urandom_range(0, 3) != 0) begin
        if (r.hour > MAX_HOUR) r.hour = '0;
        if (r.minute > MAX_MINUTE) r.minute = '0;
      end
      if ($urandom_range(0, 3) != 0) r.second = SECOND_ZERO;
      days = word[DAYS_LSB +: DAYS_W];
      r.weekday = DOW_W'($urandom_range(1, 7));
      repeat (8) begin
        if (!days[r.weekday - 1]) r.weekday = DOW_W'($urandom_range(1, 7));
      end
      if ($urandom_range(0, 9) == 0) r.weekday = DOW_NONE;
    end else if (pick < 65) begin
      r.cmd = CMD_CHECK;
    end else if (pick < 75) begin
      r.cmd = CMD_STOP;
    end else if (pick < 90) begin
      r.cmd = CMD_SNOOZE;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    cmd_queue.push_back(r);
  endtask

  // Stimulus sequence.
  initial begin
    alarm_arr_t          words;
    logic [SNOOZE_W-1:0] len;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CHECK;
    req_ch.hour = '0;
    req_ch.minute = '0;
    req_ch.second = '0;
    req_ch.weekday = DOW_NONE;
    req_ch.now_ms = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    gen_alarms = '0;
    gen_snooze = SNOOZE_RESET;
    tick = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: stop and snooze when idle, a check on a bad weekday.
    add_req(CMD_STOP, 5'd0, 6'd0, 6'd0, 3'd1, 32'd0);
    add_req(CMD_SNOOZE, 5'd0, 6'd0, 6'd0, 3'd1, 32'd0);
    add_req(CMD_CHECK, 5'd0, 6'd0, 6'd0, DOW_NONE, 32'd0);
    add_req(CMD_CHECK, 5'd0, 6'd0, 6'd0, 3'd1, 32'd0);
    wait_idle();

    // Monday 7:30, an always-on alarm with bad stored time, a disabled twin,
    // an empty slot and Sunday 23:59; one second of snooze.
    words[0] = pack_alarm(1'b1, 7'b0000001, 5'd7, 6'd30);
    words[1] = pack_alarm(1'b1, 7'h7f, 5'd31, 6'd63);
    words[2] = pack_alarm(1'b0, 7'h7f, 5'd7, 6'd30);
    words[3] = '0;
    words[4] = pack_alarm(1'b1, 7'b1000000, 5'd23, 6'd59);
    set_config(words, 22'd1000);
    add_req(CMD_CHECK, 5'd7, 6'd30, 6'd0, 3'd1, 32'd1000);
    add_req(CMD_CHECK, 5'd7, 6'd30, 6'd0, 3'd1, 32'd1200);
    add_req(CMD_SNOOZE, 5'd0, 6'd0, 6'd0, 3'd1, 32'd2000);
    add_req(CMD_CHECK, 5'd7, 6'd31, 6'd0, DOW_NONE, 32'd5000);
    add_req(CMD_CHECK, 5'd7, 6'd31, 6'd5, 3'd1, 32'd2500);
    add_req(CMD_CHECK, 5'd7, 6'd31, 6'd10, 3'd1, 32'd3000);
    add_req(CMD_STOP, 5'd0, 6'd0, 6'd0, 3'd1, 32'd3100);
    add_req(CMD_CHECK, 5'd0, 6'd0, 6'd0, 3'd3, 32'd4000);
    add_req(CMD_CHECK, 5'd31, 6'd63, 6'd0, 3'd7, 32'd4100);
    // Snooze just before the tick wraps; the deadline lands past zero.
    add_req(CMD_SNOOZE, 5'd0, 6'd0, 6'd0, 3'd7, 32'hffff_ff00);
    add_req(CMD_CHECK, 5'd1, 6'd1, 6'd5, 3'd7, 32'h0000_0100);
    add_req(CMD_CHECK, 5'd1, 6'd1, 6'd7, 3'd7, 32'h0000_0300);
    // Deadline and an alarm fire in the same check.
    add_req(CMD_SNOOZE, 5'd0, 6'd0, 6'd0, 3'd7, 32'd10);
    add_req(CMD_CHECK, 5'd23, 6'd59, 6'd0, 3'd7, 32'd2000);
    add_req(CMD_UNUSED, 5'd31, 6'd63, 6'd63, 3'd7, 32'hffff_ffff);
    add_req(CMD_CHECK, 5'd23, 6'd59, 6'd0, 3'd7, 32'hffff_ffff);
    add_req(CMD_STOP, 5'd31, 6'd63, 6'd63, 3'd7, 32'hffff_ffff);
    wait_idle();

    // Random phases, each under its own settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int k = 0; k < NUM_ALARMS; k++) words[k] = random_alarm(p != 3);
      case (p)
        0: len = '0;
        1: len = 22'd3600000;
        2: begin
          len = SNOOZE_RESET;
          for (int k = 0; k < NUM_ALARMS; k++) words[k] = '1;
        end
        3: len = SNOOZE_W'($urandom_range(0, 3600000));
        4: len = SNOOZE_W'($urandom_range(1, 5000));
        5: len = '1;
        default: len = 22'd1;
      endcase
      set_config(words, len);
      tick = $urandom();
      repeat (ITEMS_PER_PHASE) add_random_req();
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d responses under %0d register settings.", status_checked,
             settings_used);
    $display("Predicted %0d ring starts and %0d armed snoozes.", ring_starts,
             snoozes_armed);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout with %0d requests queued and %0d responses due.",
             cmd_queue.size(), due_status.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
sv/wawsn_pkg.sv
sv/wawsn_ifs.sv
sv/wawsn_cfg_regs.sv
sv/wawsn_match.sv
sv/wawsn_core.sv
sv/weekday_alarm_with_snooze.sv
tb/tb_weekday_alarm_with_snooze.sv
